// ===== hdl/tq_pkg.sv =====
package tq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_ADD_RUN  = 3'd1;
  localparam logic [2:0] OP_ADD_HEAD = 3'd2;
  localparam logic [2:0] OP_CANCEL   = 3'd3;

  localparam logic [2:0] ST_ADDED  = 3'd0;
  localparam logic [2:0] ST_RAN    = 3'd1;
  localparam logic [2:0] ST_POPPED = 3'd2;
  localparam logic [2:0] ST_NOTDUE = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;
  localparam logic [2:0] ST_CANCEL = 3'd5;
  localparam logic [2:0] ST_FULL   = 3'd6;

  typedef struct packed {
    logic [62:0] due;
    logic [63:0] key;
    logic [31:0] id;
    logic [31:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    CM_HOLD  = 2'd0,
    CM_LEFT  = 2'd1,
    CM_RIGHT = 2'd2,
    CM_NEW   = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t  mode;
    logic        occ;
    logic [62:0] probe_time;
    logic [31:0] probe_id;
  } cell_ctl_t;

endpackage

// ===== hdl/tq_cell.sv =====
module tq_cell (
  input  logic              clk,
  input  tq_pkg::cell_ctl_t ctl,
  input  tq_pkg::entry_t    left,
  input  tq_pkg::entry_t    right,
  input  tq_pkg::entry_t    fresh,
  output tq_pkg::entry_t    data,
  output logic              gt,
  output logic              match
);
  import tq_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctl.mode)
      CM_HOLD:  data <= data;
      CM_LEFT:  data <= left;
      CM_RIGHT: data <= right;
      CM_NEW:   data <= fresh;
      default:  data <= data;
    endcase
  end

  assign gt    = ctl.occ && (data.due > ctl.probe_time);
  assign match = ctl.occ && (data.id == ctl.probe_id);

endmodule

// ===== hdl/timed_event_queue.sv =====
// An accepted request passes through the eval and apply states before the
// result turns valid in the output state, where it can be taken at once.
// A new request is taken only when the previous result has been delivered.
// The shift chain of 64 cells moves the whole queue in the apply state.
// Synchronous active-high reset empties the queue, sets next id to 1 and
// max_run_chunk to all ones. No clearing pass.
module timed_event_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [62:0] now_time,
  input  logic [62:0] due_time,
  input  logic [63:0] event_key,
  input  logic [31:0] event_tag,
  input  logic [31:0] cancel_id,
  input  logic [31:0] budget,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] event_id,
  output logic [63:0] fired_key,
  output logic [62:0] fired_time,
  output logic [31:0] late_by,
  output logic [31:0] fired_tag,
  output logic [31:0] cycles_to_run,
  output logic        queue_empty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import tq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_APPLY = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;
  logic [31:0] max_run_chunk;
  logic [CNT_W-1:0] count;
  logic [31:0] next_id;

  logic [2:0]  r_op;
  logic [62:0] r_now, r_due;
  logic [63:0] r_key;
  logic [31:0] r_tag, r_cid, r_budget;

  logic [QUEUE_DEPTH-1:0] after_bits, match_bits, gt_w, match_w;
  logic        is_due, head_due;
  logic [62:0] head_diff;
  logic [31:0] head_late;

  entry_t cells [QUEUE_DEPTH];
  cell_ctl_t ctls [QUEUE_DEPTH];
  entry_t fresh;

  logic is_add;
  logic [62:0] probe_t;
  logic [31:0] id_next;
  logic [QUEUE_DEPTH-1:0] rm_bits;
  logic do_ins, do_rm, any_match;
  logic [62:0] clamp_a, clamp_b;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign is_add    = (r_op <= OP_ADD_HEAD);
  assign probe_t   = (r_op == OP_ADD_HEAD) ? 63'd0 : r_due;
  assign id_next   = (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;

  assign fresh.due = probe_t;
  assign fresh.key = r_key;
  assign fresh.id  = next_id;
  assign fresh.tag = (r_op == OP_ADD) ? r_tag : 32'd0;

  always_comb begin
    any_match = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      any_match = any_match | match_bits[i];
      rm_bits[i] = any_match;
    end
  end

  always_comb begin
    do_ins = 1'b0;
    do_rm  = 1'b0;
    if (state == S_APPLY) begin
      if (is_add) begin
        do_ins = !(r_op == OP_ADD_RUN && is_due) && (count < CNT_W'(QUEUE_DEPTH));
      end else if (r_op == OP_CANCEL) begin
        do_rm = (r_cid != 32'd0) && any_match;
      end else begin
        do_rm = (count != '0) && head_due;
      end
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t lft, rgt;
    logic prev_after, rm_here;
    assign lft = (g == 0) ? fresh : cells[(g == 0) ? 0 : g - 1];
    assign rgt = (g == QUEUE_DEPTH - 1) ? cells[g] : cells[(g == QUEUE_DEPTH - 1) ? g : g + 1];
    assign prev_after = (g == 0) ? 1'b0 : after_bits[(g == 0) ? 0 : g - 1];
    assign rm_here = (r_op == OP_CANCEL) ? rm_bits[g] : 1'b1;

    always_comb begin
      ctls[g].occ        = (CNT_W'(g) < count);
      ctls[g].probe_time = probe_t;
      ctls[g].probe_id   = r_cid;
      if (do_ins) begin
        if (prev_after) begin
          ctls[g].mode = CM_LEFT;
        end else if (after_bits[g]) begin
          ctls[g].mode = CM_NEW;
        end else begin
          ctls[g].mode = CM_HOLD;
        end
      end else if (do_rm && rm_here) begin
        ctls[g].mode = CM_RIGHT;
      end else begin
        ctls[g].mode = CM_HOLD;
      end
    end

    tq_cell u_cell (
      .clk   (clk),
      .ctl   (ctls[g]),
      .left  (lft),
      .right (rgt),
      .fresh (fresh),
      .data  (cells[g]),
      .gt    (gt_w[g]),
      .match (match_w[g])
    );
  end

  assign clamp_a = (head_diff > {31'd0, max_run_chunk}) ? {31'd0, max_run_chunk} : head_diff;
  assign clamp_b = (clamp_a > {31'd0, r_budget}) ? {31'd0, r_budget} : clamp_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      max_run_chunk <= 32'hFFFF_FFFF;
      count         <= '0;
      next_id       <= 32'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_run_chunk <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL:  state <= S_APPLY;
        S_APPLY: begin
          state <= S_OUT;
          if (do_ins) begin
            count <= count + CNT_W'(1);
          end else if (do_rm) begin
            count <= count - CNT_W'(1);
          end
          if (do_ins || (state == S_APPLY && r_op == OP_ADD_RUN && is_due)) begin
            next_id <= id_next;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      r_op     <= opcode;
      r_now    <= now_time;
      r_due    <= due_time;
      r_key    <= event_key;
      r_tag    <= event_tag;
      r_cid    <= cancel_id;
      r_budget <= budget;
    end
    if (state == S_EVAL) begin
      is_due     <= (r_op == OP_ADD_HEAD) || (r_due <= r_now) || (r_due == 63'd0);
      head_due   <= (r_now >= cells[0].due);
      head_diff  <= cells[0].due - r_now;
      head_late  <= r_now[31:0] - cells[0].due[31:0];
      match_bits <= match_w;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        after_bits[i] <= (r_op == OP_ADD_HEAD) || (r_due <= r_now) || (r_due == 63'd0)
                         || !ctls[i].occ || gt_w[i];
      end
    end
    if (state == S_APPLY) begin
      status        <= ST_EMPTY;
      event_id      <= 32'd0;
      fired_key     <= 64'd0;
      fired_time    <= 63'd0;
      late_by       <= 32'd0;
      fired_tag     <= 32'd0;
      cycles_to_run <= 32'd0;
      if (is_add) begin
        if (r_op == OP_ADD_RUN && is_due) begin
          status     <= ST_RAN;
          fired_key  <= r_key;
          fired_time <= probe_t;
        end else if (do_ins) begin
          status   <= ST_ADDED;
          event_id <= next_id;
        end else begin
          status <= ST_FULL;
        end
      end else if (r_op == OP_CANCEL) begin
        status <= ST_CANCEL;
        if (do_rm) begin
          event_id <= r_cid;
        end
      end else if (count == '0) begin
        status <= ST_EMPTY;
      end else if (head_due) begin
        status     <= ST_POPPED;
        event_id   <= cells[0].id;
        fired_key  <= cells[0].key;
        fired_time <= cells[0].due;
        late_by    <= head_late;
        fired_tag  <= cells[0].tag;
      end else begin
        status        <= ST_NOTDUE;
        cycles_to_run <= clamp_b[31:0];
      end
      if (do_ins) begin
        queue_empty <= 1'b0;
      end else if (do_rm) begin
        queue_empty <= (count == CNT_W'(1));
      end else begin
        queue_empty <= (count == '0);
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tq_pkg::*;

  localparam logic [2:0] OP_DISPATCH = 3'd4;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] event_id;
    logic [63:0] fired_key;
    logic [62:0] fired_time;
    logic [31:0] late_by;
    logic [31:0] fired_tag;
    logic [31:0] cycles_to_run;
    logic        queue_empty;
  } outcome_t;

  class event_scoreboard;
    logic [62:0] q_time[$];
    logic [63:0] q_key[$];
    logic [31:0] q_id[$];
    logic [31:0] q_tag[$];
    logic [31:0] id_next;
    logic [31:0] chunk;
    outcome_t    pending[$];
    int          errors;

    function void clear();
      q_time.delete(); q_key.delete(); q_id.delete(); q_tag.delete();
      pending.delete();
      id_next = 32'd1;
      chunk = '1;
      errors = 0;
    endfunction

    function logic [31:0] grab_id();
      logic [31:0] r;
      r = id_next;
      id_next = id_next + 32'd1;
      if (id_next == 0) id_next = 32'd1;
      return r;
    endfunction

    function void note_request(logic [2:0] op, logic [62:0] now, logic [62:0] due,
                               logic [63:0] key, logic [31:0] tag, logic [31:0] cid,
                               logic [31:0] bud);
      outcome_t o;
      bit is_due;
      logic [62:0] t;
      logic [62:0] n;
      int pos;
      o = '{default: 0};
      if (op <= OP_ADD_HEAD) begin
        is_due = (op == OP_ADD_HEAD) || due <= now || due == 0;
        t = (op == OP_ADD_HEAD) ? 63'd0 : due;
        if (op == OP_ADD_RUN && is_due) begin
          void'(grab_id());
          o.status = ST_RAN;
          o.fired_key = key;
          o.fired_time = t;
        end else if (q_time.size() >= QUEUE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          o.event_id = grab_id();
          pos = 0;
          if (!is_due) begin
            pos = q_time.size();
            foreach (q_time[i]) if (q_time[i] > t) begin
              pos = i;
              break;
            end
          end
          q_time.insert(pos, t);
          q_key.insert(pos, key);
          q_id.insert(pos, o.event_id);
          q_tag.insert(pos, op == OP_ADD ? tag : 32'd0);
          o.status = ST_ADDED;
        end
      end else if (op == OP_CANCEL) begin
        o.status = ST_CANCEL;
        if (cid != 0) foreach (q_id[i]) if (q_id[i] == cid) begin
          o.event_id = cid;
          q_time.delete(i); q_key.delete(i); q_id.delete(i); q_tag.delete(i);
          break;
        end
      end else if (q_time.size() == 0) begin
        o.status = ST_EMPTY;
      end else if (now >= q_time[0]) begin
        o.status = ST_POPPED;
        o.event_id = q_id[0];
        o.fired_key = q_key[0];
        o.fired_time = q_time[0];
        o.late_by = 32'(now - q_time[0]);
        o.fired_tag = q_tag[0];
        void'(q_time.pop_front()); void'(q_key.pop_front());
        void'(q_id.pop_front()); void'(q_tag.pop_front());
      end else begin
        n = q_time[0] - now;
        if (n > 63'(chunk)) n = 63'(chunk);
        if (n > 63'(bud)) n = 63'(bud);
        o.status = ST_NOTDUE;
        o.cycles_to_run = n[31:0];
      end
      o.queue_empty = q_time.size() == 0;
      pending.push_back(o);
    endfunction

    function void check_result(outcome_t a);
      outcome_t e;
      if (pending.size() == 0) begin
        $error("unexpected result, status %0d", a.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.event_id !== e.event_id) begin
        $error("event_id exp %0h got %0h", e.event_id, a.event_id); errors++;
      end
      if (a.fired_key !== e.fired_key) begin
        $error("fired_key exp %0h got %0h", e.fired_key, a.fired_key); errors++;
      end
      if (a.fired_time !== e.fired_time) begin
        $error("fired_time exp %0h got %0h", e.fired_time, a.fired_time); errors++;
      end
      if (a.late_by !== e.late_by) begin
        $error("late_by exp %0h got %0h", e.late_by, a.late_by); errors++;
      end
      if (a.fired_tag !== e.fired_tag) begin
        $error("fired_tag exp %0h got %0h", e.fired_tag, a.fired_tag); errors++;
      end
      if (a.cycles_to_run !== e.cycles_to_run) begin
        $error("cycles_to_run exp %0h got %0h", e.cycles_to_run, a.cycles_to_run);
        errors++;
      end
      if (a.queue_empty !== e.queue_empty) begin
        $error("queue_empty exp %0d got %0d", e.queue_empty, a.queue_empty); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic [2:0] opcode = 0;
  logic [62:0] now_time = 0, due_time = 0;
  logic [63:0] event_key = 0;
  logic [31:0] event_tag = 0, cancel_id = 0, budget = 0;
  logic out_valid, out_stall = 0;
  logic [2:0] status;
  logic [31:0] event_id, late_by, fired_tag, cycles_to_run;
  logic [63:0] fired_key;
  logic [62:0] fired_time;
  logic queue_empty;
  logic cfg_valid = 0, cfg_ready;
  logic [31:0] cfg_data = 0;

  int send_idle = 0, recv_idle = 0;
  bit hold_off = 0;
  logic [62:0] clock_now;
  logic [31:0] last_id;
  event_scoreboard sb;

  timed_event_queue dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // receiver
  always @(posedge clk) begin
    if (out_valid && !out_stall && !rst)
      sb.check_result('{status, event_id, fired_key, fired_time, late_by, fired_tag,
                        cycles_to_run, queue_empty});
    if (out_valid && !out_stall && status == ST_ADDED) last_id <= event_id;
    out_stall <= hold_off || ($urandom_range(99) < recv_idle);
  end

  task automatic send_request(logic [2:0] op, logic [62:0] now, logic [62:0] due,
                              logic [63:0] key, logic [31:0] tag, logic [31:0] cid,
                              logic [31:0] bud);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1;
    opcode <= op; now_time <= now; due_time <= due; event_key <= key;
    event_tag <= tag; cancel_id <= cid; budget <= bud;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, now, due, key, tag, cid, bud);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_chunk(logic [31:0] v);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.chunk = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_request();
    int r;
    logic [62:0] due;
    logic [31:0] cid;
    r = $urandom_range(99);
    if ($urandom_range(3) == 0) clock_now = clock_now + $urandom_range(200);
    if ($urandom_range(7) == 0) due = 63'({$urandom(), $urandom()});
    else due = clock_now + $urandom_range(400) - 100;
    if ($urandom_range(3) == 0) cid = $urandom();
    else cid = last_id - $urandom_range(12);
    if (r < 35) send_request(OP_ADD, clock_now, due, rand64(), $urandom(), $urandom(),
                             $urandom());
    else if (r < 45) send_request(OP_ADD_RUN, clock_now, due, rand64(), $urandom(),
                                  $urandom(), $urandom());
    else if (r < 50) send_request(OP_ADD_HEAD, clock_now, due, rand64(), $urandom(),
                                  $urandom(), $urandom());
    else if (r < 62) send_request(OP_CANCEL, clock_now, due, rand64(), $urandom(), cid,
                                  $urandom());
    else send_request(3'($urandom_range(OP_DISPATCH, 7)), clock_now, due, rand64(),
                      $urandom(), cid, ($urandom_range(3) == 0) ? $urandom_range(50)
                      : $urandom());
  endtask

  initial begin
    #5ms;
    $display("timed_event_queue regression: fail");
    $finish;
  end

  initial begin
    logic [62:0] big;
    sb = new();
    sb.clear();
    clock_now = 1000;
    last_id = 1;
    big = '1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    send_request(OP_DISPATCH, 0, 0, 0, 0, 0, 0);
    send_request(OP_CANCEL, 0, 0, 0, 0, 0, 0);
    send_request(OP_ADD, 10, 500, '1, '1, 0, 0);
    send_request(OP_ADD, 10, 500, 64'h1234, 32'h55, 0, 0);
    send_request(OP_ADD, 10, big, 64'hA5A5, 32'h5A5A, 0, 0);
    send_request(OP_ADD, 10, 0, 64'h77, 7, 0, 0);
    send_request(OP_ADD_RUN, 10, 5, 64'h99, 1, 0, 0);
    send_request(OP_ADD_RUN, 10, 700, 64'h98, 1, 0, 0);
    send_request(OP_ADD_HEAD, 10, 900, 64'h97, 1, 0, 0);
    send_request(OP_DISPATCH, 20, 0, 0, 0, 0, '1);
    send_request(3'd7, 20, 0, 0, 0, 0, '1);
    send_request(OP_DISPATCH, 20, 0, 0, 0, 0, '1);
    send_request(OP_DISPATCH, 20, 0, 0, 0, 0, 0);
    send_request(3'd5, 20, 0, 0, 0, 0, 40);
    send_request(OP_CANCEL, 0, 0, 0, 0, 3, 0);
    send_request(OP_CANCEL, 0, 0, 0, 0, '1, 0);
    send_request(3'd6, big, 0, 0, 0, 0, '1);
    write_chunk(1);
    send_request(OP_ADD, 10, 900, 1, 1, 0, 0);
    send_request(OP_DISPATCH, 20, 0, 0, 0, 0, '1);
    write_chunk(0);
    send_request(OP_DISPATCH, 20, 0, 0, 0, 0, '1);
    write_chunk('1);

    // fill to full, then overflow, starting while the receiver holds off
    fork
      begin
        hold_off <= 1;
        repeat (300) @(posedge clk);
        hold_off <= 0;
      end
      repeat (QUEUE_DEPTH + 4)
        send_request(OP_ADD, 0, 63'($urandom_range(1, 50)), rand64(), $urandom(), 0, 0);
    join
    send_request(OP_ADD_RUN, 100, 5, 64'h5, 0, 0, 0);
    repeat (QUEUE_DEPTH + 2) send_request(OP_DISPATCH, 100, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 32 : (ph == 1) ? 45 : 0;
      recv_idle = (ph == 0) ? 45 : (ph == 1) ? 32 : 0;
      write_chunk(ph == 0 ? 32'd37 : ph == 1 ? $urandom() : 32'hFFFF_FFFF);
      repeat (400) random_request();
    end

    send_idle = 0;
    recv_idle = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("timed_event_queue regression: pass");
    else
      $display("timed_event_queue regression: fail");
    $finish;
  end
endmodule
